FILE: rtl/lfu_cache_table_top_assert.svh
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shared property shapes for the checker, clocked on clk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_TOP_ASSERT_SVH
`define LFU_CACHE_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfu_cache_table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfu_cache_table: next-cycle check failed");

`endif

FILE: rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, constants and control structs of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int DATA_W         = 32;
  localparam int TOUCH_W        = 32;
  localparam int CAP_W          = 5;
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] PUT_RESULT = 32'h0000_0000;

  // opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch a new item, clear scan trackers
    logic scan;    // examine one entry
    logic commit;  // update the table and load the result register
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // current scan entry is the last one
    logic out_free;   // result register can take a new result
  } lfu_sts_t;

endpackage

FILE: rtl/lfu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lfu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept an item, scan every entry, then commit the result.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output lfu_pkg::lfu_cmd_t cmd,
  input  lfu_pkg::lfu_sts_t sts
);
  import lfu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.scan   = (state == ST_SCAN);
    cmd.commit = (state == ST_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state    <= ST_SCAN;
            in_stall <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (sts.scan_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the result register is free
          if (sts.out_free) begin
            state    <= ST_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/lfu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_dp
// Entry store, sequential scan trackers, table update and result register.
// ----------------------------------------------------------------------------
module lfu_dp #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lfu_pkg::lfu_cmd_t           cmd,
  output lfu_pkg::lfu_sts_t           sts,
  input  logic                        opcode,
  input  logic [lfu_pkg::DATA_W-1:0]  key,
  input  logic [lfu_pkg::DATA_W-1:0]  value,
  input  logic                        cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [lfu_pkg::DATA_W-1:0]  read_value
);
  import lfu_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = DATA_W + DATA_W + COUNT_BITS + TOUCH_W;

  // item latched at accept
  logic                  op_q;
  logic [DATA_W-1:0]     key_q;
  logic [DATA_W-1:0]     value_q;

  // table state
  logic [ENTRIES-1:0]    valid_bits;
  logic [ENTRIES-1:0]    valid_bits_next;
  logic [TOUCH_W-1:0]    touch_clock;
  logic [OCC_W-1:0]      occupancy;
  logic [CAP_W-1:0]      capacity;

  // scan
  logic [IDX_W-1:0]      scan_idx;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_slot;
  logic [DATA_W-1:0]     hit_value;
  logic [COUNT_BITS-1:0] hit_count;
  logic                  vic_found;
  logic [IDX_W-1:0]      vic_slot;
  logic [COUNT_BITS-1:0] vic_count;
  logic [TOUCH_W-1:0]    vic_age;
  logic                  free_found;
  logic [IDX_W-1:0]      free_slot;

  // entry store
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic [DATA_W-1:0]     e_key;
  logic [DATA_W-1:0]     e_value;
  logic [COUNT_BITS-1:0] e_count;
  logic [TOUCH_W-1:0]    e_touch;
  logic                  e_valid;
  logic [TOUCH_W-1:0]    e_age;
  logic                  e_match;
  logic                  e_better;

  // commit
  logic [31:0]           cap_eff;
  logic                  occ_full;
  logic                  evict;
  logic                  ins_en;
  logic [IDX_W-1:0]      ins_slot;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic [DATA_W-1:0]     res_value;

  lfu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry 0 is read while idle so its word is ready on the first scan cycle
  assign ram_raddr = cmd.scan ? scan_idx + IDX_W'(1) : '0;

  assign {e_key, e_value, e_count, e_touch} = ram_rdata;
  assign e_valid  = valid_bits[scan_idx];
  assign e_age    = touch_clock - e_touch;
  assign e_match  = e_valid && (e_key == key_q);
  assign e_better = e_valid && (!vic_found || (e_count < vic_count) ||
                    ((e_count == vic_count) && (e_age > vic_age)));

  assign sts.scan_last = (scan_idx == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_valid || !out_stall;

  assign cap_eff  = (32'(capacity) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(capacity);
  assign occ_full = 32'(occupancy) >= cap_eff;
  assign cnt_sat  = (hit_count == '1) ? hit_count : hit_count + COUNT_BITS'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_slot;
    ram_wdata = {key_q, (op_q == OP_PUT) ? value_q : hit_value, cnt_sat, touch_clock};
    evict     = 1'b0;
    ins_en    = 1'b0;
    ins_slot  = free_slot;
    if (cmd.commit) begin
      if (hit_found) begin
        ram_we = 1'b1;
      end else if ((op_q == OP_PUT) && (cap_eff != 32'd0)) begin
        evict = occ_full && vic_found;
        if (evict && !(free_found && (free_slot < vic_slot))) begin
          ins_slot = vic_slot;
        end
        ins_en = evict || free_found;
        if (ins_en) begin
          ram_we    = 1'b1;
          ram_waddr = ins_slot;
          ram_wdata = {key_q, value_q, COUNT_BITS'(1), touch_clock};
        end
      end
    end
  end

  // drop the victim first, then mark the inserted slot
  always_comb begin
    valid_bits_next = valid_bits;
    if (evict) begin
      valid_bits_next[vic_slot] = 1'b0;
    end
    if (ins_en) begin
      valid_bits_next[ins_slot] = 1'b1;
    end
  end

  always_comb begin
    if (op_q == OP_PUT) begin
      res_value = PUT_RESULT;
    end else if (hit_found) begin
      res_value = hit_value;
    end else begin
      res_value = MISS_VALUE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits  <= '0;
      touch_clock <= '0;
      occupancy   <= '0;
      capacity    <= CAP_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (ram_we) begin
        touch_clock <= touch_clock + TOUCH_W'(1);
      end
      valid_bits <= valid_bits_next;
      if (ins_en && !evict) begin
        occupancy <= occupancy + OCC_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, scan trackers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= opcode;
      key_q      <= key;
      value_q    <= value;
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end
    if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (e_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= scan_idx;
        hit_value <= e_value;
        hit_count <= e_count;
      end
      if (e_better) begin
        vic_found <= 1'b1;
        vic_slot  <= scan_idx;
        vic_count <= e_count;
        vic_age   <= e_age;
      end
      if (!e_valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= scan_idx;
      end
    end
    if (cmd.commit) begin
      hit        <= hit_found;
      read_value <= res_value;
    end
  end

endmodule

FILE: rtl/lfu_cache_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// Least-frequently-used key/value cache with least-recently-touched tie break.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries opcode, key and value: a get
// looks a key up, a put inserts or updates it. The output channel
// (out_valid/out_stall) returns one item per input item: hit and read_value
// (stored value on a get hit, all ones on a get miss, zero on any put).
// cfg_we/cfg_wdata write the capacity register; write it only while idle.
// For each item, one entry of the single-read-port entry RAM is examined
// per cycle for the key match, the eviction victim and the first free slot,
// then the finish state commits the table update and loads the result
// register, then the idle state accepts the next item.
// The result register sits apart from the input, so the next item is taken
// and scanned while a result still waits; only the commit waits for it.
// Reset is synchronous: all entries invalid, touch clock and occupancy zero,
// capacity 16. The entry RAM itself is not cleared; valid bits cover it.
// ----------------------------------------------------------------------------
module lfu_cache_table_top #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic signed [lfu_pkg::DATA_W-1:0] key,
  input  logic signed [lfu_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic signed [lfu_pkg::DATA_W-1:0] read_value,
  input  logic                              cfg_we,
  input  logic        [lfu_pkg::CAP_W-1:0]  cfg_wdata
);
  import lfu_pkg::*;

  lfu_cmd_t          cmd;
  lfu_sts_t          sts;
  logic [DATA_W-1:0] key_u;
  logic [DATA_W-1:0] value_u;
  logic [DATA_W-1:0] read_value_u;

  assign key_u      = key;
  assign value_u    = value;
  assign read_value = read_value_u;

  // sequencer: accept, scan, commit
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // entry store, scan trackers and result register
  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .key        (key_u),
    .value      (value_u),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value_u)
  );

endmodule

FILE: rtl/lfu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_chk
// Port-level checks of the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_top_assert.svh"

module lfu_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       hit,
  input logic [lfu_pkg::DATA_W-1:0] read_value
);
  import lfu_pkg::*;

  // a miss only ever reports the get-miss or the put result
  `LFU_ASSERT_SAME(a_miss_value, out_valid && !hit, (read_value == MISS_VALUE) || (read_value == PUT_RESULT))

  // one item at a time: an accepted item blocks the input
  `LFU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a fresh result comes with the input reopened
  `LFU_ASSERT_SAME(a_result_frees_input, $rose(out_valid), !in_stall)

  // a stalled result holds
  `LFU_ASSERT_NEXT(a_result_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(read_value))

endmodule

bind lfu_cache_table_top lfu_chk u_lfu_chk (.*);
